// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion checked at every rising clock edge, off while reset is asserted.
`define ASSERT_CLK(label, clock, rst_n, prop) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Implication checked at every rising clock edge, off while reset is asserted.
`define ASSERT_IMP(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/cmie_pkg.sv -----
`default_nettype none
package cmie_pkg;

	localparam int CONCEPTS = 10;
	localparam int ROUNDS = 3;
	localparam int IDX_W = $clog2(CONCEPTS);
	localparam int RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
	localparam int SLOT_W = 7;
	localparam int VAL_W = 16;
	localparam int PRED_W = 13;
	localparam int TOT_W = 24;
	localparam int PROD_W = 32;
	localparam int ACC_W = PROD_W + $clog2(CONCEPTS) + 1;
	localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};
	localparam logic [PRED_W-1:0] ONE_Q12 = 13'd4096;

	localparam logic [1:0] OP_WEIGHT = 2'd0;
	localparam logic [1:0] OP_CONCEPT = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	// Control word broadcast from the sequencer to every cell.
	typedef struct packed {
		logic load_w;
		logic load_a;
		logic mul;
		logic add;
		logic clr;
		logic sig;
		logic [IDX_W-1:0] step;
	} cell_ctl_t;

	// Sigmoid of half the net sum, piecewise linear on the rounded magnitude.
	function automatic logic [PRED_W-1:0] sigmoid_half(input logic signed [ACC_W-1:0] net);
		logic [ACC_W-1:0] mag;
		logic [ACC_W:0] sum;
		logic [ACC_W:0] q;
		logic [PRED_W-1:0] y;
		mag = net[ACC_W-1] ? (~net + 1'b1) : net;
		sum = {1'b0, mag} + (ACC_W+1)'(4096);
		q = sum >> 13;
		if (q >= (ACC_W+1)'(20480)) begin
			y = ONE_Q12;
		end else if (q >= (ACC_W+1)'(9728)) begin
			y = 13'd3456 + PRED_W'(q >> 5);
		end else if (q >= (ACC_W+1)'(4096)) begin
			y = 13'd2560 + PRED_W'(q >> 3);
		end else begin
			y = 13'd2048 + PRED_W'(q >> 2);
		end
		return net[ACC_W-1] ? (ONE_Q12 - y) : y;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/cmie_cell.sv -----
`default_nettype none
module cmie_cell (
	input wire logic clk,
	input wire cmie_pkg::cell_ctl_t ctl,
	input wire logic [cmie_pkg::IDX_W-1:0] cell_idx,
	input wire logic [cmie_pkg::SLOT_W-1:0] slot,
	input wire logic [cmie_pkg::VAL_W-1:0] val,
	input wire logic [cmie_pkg::VAL_W-1:0] a_in,
	output logic [cmie_pkg::VAL_W-1:0] a_out
);
	import cmie_pkg::*;

	// Column of the weight matrix that feeds this concept.
	logic [VAL_W-1:0] w_q [CONCEPTS];
	logic [VAL_W-1:0] a_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [IDX_W:0] wsum;
	logic [IDX_W-1:0] widx;

	// Row of the weight that pairs with the concept now held here.
	assign wsum = {1'b0, cell_idx} + {1'b0, ctl.step};
	assign widx = (wsum >= (IDX_W+1)'(CONCEPTS)) ? IDX_W'(wsum - (IDX_W+1)'(CONCEPTS))
		: wsum[IDX_W-1:0];

	// Weight loads pick the slot row*CONCEPTS + this column.
	always_ff @(posedge clk) begin
		for (int n = 0; n < CONCEPTS; n++) begin
			if (ctl.load_w && slot == SLOT_W'(n * CONCEPTS) + SLOT_W'(cell_idx)) begin
				w_q[n] <= val;
			end
		end
	end

	// Concept register: loaded, rotated around the ring, or replaced by the sigmoid.
	always_ff @(posedge clk) begin
		if (ctl.load_a && slot == SLOT_W'(cell_idx)) begin
			a_q <= val;
		end else if (ctl.mul) begin
			a_q <= a_in;
		end else if (ctl.sig) begin
			a_q <= VAL_W'(sigmoid_half(acc_q));
		end
	end

	// Multiply, then accumulate in the next cycle.
	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_q <= $signed(a_q) * $signed(w_q[widx]);
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.add) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

	assign a_out = a_q;
endmodule
`default_nettype wire

// ----- rtl/cmie_divider.sv -----
`default_nettype none
module cmie_divider (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [cmie_pkg::TOT_W-1:0] dividend,
	input wire logic [15:0] divisor,
	output logic done,
	output logic [cmie_pkg::TOT_W-1:0] quotient
);
	import cmie_pkg::*;

	logic busy_q;
	logic [4:0] cnt_q;
	logic [15:0] div_q;
	logic [15:0] rem_q;
	logic [TOT_W-1:0] quo_q;
	logic [16:0] sh;
	logic take;

	// One quotient bit a cycle, restoring form.
	assign sh = {rem_q, quo_q[TOT_W-1]};
	assign take = (sh >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'(TOT_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? 16'(sh - {1'b0, div_q}) : sh[15:0];
			quo_q <= {quo_q[TOT_W-2:0], take};
		end
	end

	assign done = busy_q && (cnt_q == 5'(TOT_W - 1));
	assign quotient = {quo_q[TOT_W-2:0], take};
endmodule
`default_nettype wire

// ----- rtl/cognitive_map_inference_error.sv -----
// Channel | Dir | Handshake          | Contents
// s_axis  | in  | tvalid/tready      | tdata: slot_index, item_value; tuser: opcode
// m_axis  | out | tvalid/tready      | tdata: predicted, abs, total, mean; tuser: kind
// cfg     | in  | cfg_we             | cfg_index 0 mean_divisor, 1 target_concept
// Weight and plain concept words are stored when accepted. The last concept of a record
// runs ROUNDS rounds in the ring, each a multiply-accumulate pass over the concepts, a
// drain and a sigmoid step; the result is then formed (ST_RESULT) and posted (ST_PUSH).
// A finish word runs the serial divider first, but at divisor 0 goes straight to posting.
// Reset clears the sequencer, the handshake flags and the error total.
// A result waits in the output register; a new result waits until it is taken.
`default_nettype none
`include "assert_macros.svh"
module cognitive_map_inference_error (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [23:0] s_tdata, // slot_index[6:0], item_value[22:7], zero pad
	input wire logic [1:0] s_tuser, // opcode[1:0]
	output logic m_tvalid,
	input wire logic m_tready,
	// predicted_value[12:0], abs_error[28:13], total_error[52:29], mean_error[76:53]
	output logic [79:0] m_tdata,
	output logic [0:0] m_tuser, // result_kind[0]
	input wire logic cfg_we,
	input wire logic [0:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	import cmie_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MAC = 7'b0000010,
		ST_DRAIN = 7'b0000100,
		ST_SIG = 7'b0001000,
		ST_RESULT = 7'b0010000,
		ST_DIV = 7'b0100000,
		ST_PUSH = 7'b1000000
	} state_t;

	state_t state_q;
	logic [15:0] divisor_q;
	logic [3:0] target_q;
	logic [IDX_W-1:0] step_q;
	logic [RND_W-1:0] round_q;
	logic add_q;
	logic [TOT_W-1:0] total_q;
	logic [VAL_W-1:0] orig_q [CONCEPTS];
	logic [VAL_W-1:0] a_arr [CONCEPTS];
	logic pend_kind_q;
	logic [PRED_W-1:0] pend_pred_q;
	logic [VAL_W-1:0] pend_err_q;
	logic [TOT_W-1:0] pend_total_q;
	logic [TOT_W-1:0] pend_mean_q;
	logic out_valid_q;
	logic [79:0] out_data_q;
	logic out_kind_q;

	logic accept;
	logic [1:0] op;
	logic [SLOT_W-1:0] slot;
	logic [VAL_W-1:0] val;
	cell_ctl_t ctl;
	logic [IDX_W-1:0] tsel;
	logic [PRED_W-1:0] pred;
	logic signed [17:0] diff;
	logic [16:0] err;
	logic [TOT_W:0] tsum;
	logic div_start;
	logic div_done;
	logic [TOT_W-1:0] div_quo;
	logic push_ok;

	assign op = s_tuser;
	assign slot = s_tdata[6:0];
	assign val = s_tdata[22:7];
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign push_ok = !out_valid_q || m_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= 16'd700;
			target_q <= 4'd9;
		end else if (cfg_we) begin
			unique case (cfg_index)
				1'b0: divisor_q <= cfg_data;
				1'b1: target_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Control word for the ring of cells.
	always_comb begin
		ctl.load_w = accept && (op == OP_WEIGHT);
		ctl.load_a = accept && (op == OP_CONCEPT);
		ctl.mul = (state_q == ST_MAC);
		ctl.add = add_q;
		ctl.clr = (state_q == ST_MAC) && (step_q == '0);
		ctl.sig = (state_q == ST_SIG);
		ctl.step = step_q;
	end

	// Ring of cells; each takes its concept from the next cell up.
	for (genvar g = 0; g < CONCEPTS; g++) begin : g_cell
		cmie_cell u_cell (
			.clk(clk),
			.ctl(ctl),
			.cell_idx(IDX_W'(g)),
			.slot(slot),
			.val(val),
			.a_in(a_arr[(g + 1) % CONCEPTS]),
			.a_out(a_arr[g])
		);
	end

	// Concept values as loaded, kept for the error.
	always_ff @(posedge clk) begin
		if (accept && op == OP_CONCEPT && slot < SLOT_W'(CONCEPTS)) begin
			orig_q[slot[IDX_W-1:0]] <= val;
		end
	end

	// Error of the target concept against its loaded value.
	assign tsel = (32'(target_q) < CONCEPTS) ? IDX_W'(target_q) : IDX_W'(CONCEPTS - 1);
	assign pred = a_arr[tsel][PRED_W-1:0];
	assign diff = 18'($signed(orig_q[tsel])) - $signed({5'b0, pred});
	assign err = diff[17] ? 17'(-diff) : diff[16:0];
	assign tsum = {1'b0, total_q} + (TOT_W+1)'(err);

	assign div_start = accept && (op == OP_FINISH) && (divisor_q != '0);

	cmie_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(total_q),
		.divisor(divisor_q),
		.done(div_done),
		.quotient(div_quo)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			round_q <= '0;
			add_q <= 1'b0;
			total_q <= '0;
		end else begin
			add_q <= (state_q == ST_MAC);
			unique case (state_q)
				ST_IDLE: begin
					if (accept && op == OP_CONCEPT && slot == SLOT_W'(CONCEPTS - 1)) begin
						state_q <= ST_MAC;
						step_q <= '0;
						round_q <= '0;
					end else if (accept && op == OP_FINISH) begin
						total_q <= '0;
						state_q <= (divisor_q != '0) ? ST_DIV : ST_PUSH;
					end
				end
				ST_MAC: begin
					if (step_q == IDX_W'(CONCEPTS - 1)) begin
						step_q <= '0;
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DRAIN: state_q <= ST_SIG;
				ST_SIG: begin
					if (round_q == RND_W'(ROUNDS - 1)) begin
						state_q <= ST_RESULT;
					end else begin
						round_q <= round_q + 1'b1;
						state_q <= ST_MAC;
					end
				end
				ST_RESULT: begin
					total_q <= tsum[TOT_W] ? TOTAL_MAX : tsum[TOT_W-1:0];
					state_q <= ST_PUSH;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Pending result fields.
	always_ff @(posedge clk) begin
		if (accept && op == OP_FINISH) begin
			pend_kind_q <= 1'b1;
			pend_pred_q <= '0;
			pend_err_q <= '0;
			pend_total_q <= total_q;
			pend_mean_q <= TOTAL_MAX;
		end else if (state_q == ST_RESULT) begin
			pend_kind_q <= 1'b0;
			pend_pred_q <= pred;
			pend_err_q <= err[15:0];
			pend_total_q <= tsum[TOT_W] ? TOTAL_MAX : tsum[TOT_W-1:0];
			pend_mean_q <= '0;
		end else if (state_q == ST_DIV && div_done) begin
			pend_mean_q <= div_quo;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PUSH && push_ok) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && push_ok) begin
			out_kind_q <= pend_kind_q;
			out_data_q <= {3'b0, pend_mean_q, pend_total_q, pend_err_q, pend_pred_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_kind_q;

	`ASSERT_CLK(a_state_onehot, clk, arst_n, $onehot(state_q))
	`ASSERT_IMP(a_rise_from_push, clk, arst_n, $rose(m_tvalid), $past(state_q == ST_PUSH))
	`ASSERT_IMP(a_mac_step, clk, arst_n, state_q == ST_MAC, step_q < IDX_W'(CONCEPTS))
endmodule
`default_nettype wire

// ----- verif/tb_cognitive_map_inference_error.sv -----
`default_nettype none

// Expected-result store and map predictor for the cognitive map block.
class map_scoreboard;
	logic signed [15:0] weights[100];
	logic signed [15:0] cur_vals[10];
	logic signed [15:0] orig_vals[10];
	int unsigned err_total;
	int unsigned divisor;
	int unsigned target;
	logic [79:0] exp_data[$];
	logic exp_kind[$];
	int errors;

	function new();
		foreach (weights[i]) weights[i] = '0;
		foreach (cur_vals[i]) begin
			cur_vals[i] = '0;
			orig_vals[i] = '0;
		end
		err_total = 0;
		divisor = 700;
		target = 9;
		errors = 0;
	endfunction

	function void write_reg(int idx, logic [15:0] data);
		if (idx == 0) divisor = data;
		else target = data[3:0];
	endfunction

	function int pending();
		return exp_data.size();
	endfunction

	// Sigmoid of half the net sum on the rounded magnitude.
	function logic [12:0] squash(longint net);
		longint mag;
		longint q;
		int y;
		mag = (net < 0) ? -net : net;
		q = (mag + 4096) >>> 13;
		if (q >= 20480) y = 4096;
		else if (q >= 9728) y = 3456 + int'(q >>> 5);
		else if (q >= 4096) y = 2560 + int'(q >>> 3);
		else y = 2048 + int'(q >>> 2);
		return (net < 0) ? 13'(4096 - y) : 13'(y);
	endfunction

	// Runs the rounds of inference and queues the record result.
	function void run_map();
		logic signed [15:0] nxt[10];
		longint acc;
		int t;
		int diff;
		logic [12:0] pred;
		int unsigned err;
		for (int r = 0; r < 3; r++) begin
			for (int m = 0; m < 10; m++) begin
				acc = 0;
				for (int n = 0; n < 10; n++)
					acc += longint'(cur_vals[n]) * longint'(weights[n * 10 + m]);
				nxt[m] = 16'(squash(acc));
			end
			cur_vals = nxt;
		end
		t = (target < 10) ? target : 9;
		pred = cur_vals[t][12:0];
		diff = int'(orig_vals[t]) - int'(pred);
		err = (diff < 0) ? -diff : diff;
		err_total += err;
		if (err_total > 24'hFFFFFF) err_total = 24'hFFFFFF;
		exp_data.push_back({3'b0, 24'd0, 24'(err_total), 16'(err), pred});
		exp_kind.push_back(1'b0);
	endfunction

	// Notes one accepted input word.
	function void note_word(logic [1:0] op, logic [6:0] slot, logic [15:0] val);
		int unsigned mean;
		if (op == cmie_pkg::OP_WEIGHT) begin
			if (slot < 100) weights[slot] = val;
		end else if (op == cmie_pkg::OP_CONCEPT) begin
			if (slot < 10) begin
				cur_vals[slot] = val;
				orig_vals[slot] = val;
				if (slot == 9) run_map();
			end
		end else if (op == cmie_pkg::OP_FINISH) begin
			mean = (divisor != 0) ? err_total / divisor : 24'hFFFFFF;
			exp_data.push_back({3'b0, 24'(mean), 24'(err_total), 16'd0, 13'd0});
			exp_kind.push_back(1'b1);
			err_total = 0;
		end
	endfunction

	// Compares one accepted result word with the oldest expectation.
	function void check_word(logic [79:0] data, logic kind);
		logic [79:0] e;
		logic ek;
		if (exp_data.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result word %h kind %b", data, kind);
			return;
		end
		e = exp_data.pop_front();
		ek = exp_kind.pop_front();
		if (kind !== ek || data[12:0] !== e[12:0] || data[28:13] !== e[28:13] ||
				data[52:29] !== e[52:29] || data[76:53] !== e[76:53]) begin
			errors++;
			if (errors <= 10)
				$display("mismatch kind %b/%b pred %0d/%0d abs %0d/%0d tot %0d/%0d mean %0d/%0d",
					ek, kind, e[12:0], data[12:0], e[28:13], data[28:13],
					e[52:29], data[52:29], e[76:53], data[76:53]);
		end
	endfunction
endclass

module tb_cognitive_map_inference_error;
	timeunit 1ns;
	timeprecision 1ps;
	import cmie_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int REG_DIVISOR = 0;
	localparam int REG_TARGET = 1;
	localparam int PHASE_ITEMS = 320;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [23:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [79:0] m_tdata;
	logic [0:0] m_tuser;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [15:0] cfg_data;

	map_scoreboard sb;
	bit calm;
	int hold_request;
	int items_sent;

	cognitive_map_inference_error u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int next_gap();
		int r;
		r = $urandom_range(99);
		if (calm || r < 60) return 0;
		if (r < 90) return $urandom_range(3, 1);
		if (r < 98) return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Values lean toward the extremes now and then.
	function automatic logic [15:0] pick_value();
		case ($urandom_range(9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'(4096 * ($urandom_range(1) ? 1 : -1));
			3: return 16'(int'($urandom_range(4096)) - 2048);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_word(logic [1:0] op, logic [6:0] slot, logic [15:0] val);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, val, slot};
		do @(posedge clk); while (!s_tready);
		sb.note_word(op, slot, val);
		items_sent++;
	endtask

	// Waits for every expected word, then for the longest busy stretch.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= 1'(idx);
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	// One record: some or all of the first nine concepts, then the last one.
	task automatic send_record(bit full);
		int order[9];
		foreach (order[i]) order[i] = i;
		order.shuffle();
		foreach (order[i])
			if (full || $urandom_range(2) == 0) send_word(OP_CONCEPT, 7'(order[i]), pick_value());
		send_word(OP_CONCEPT, 7'd9, pick_value());
	endtask

	task automatic send_noise();
		case ($urandom_range(2))
			0: send_word(OP_NONE, 7'($urandom), 16'($urandom));
			1: send_word(OP_WEIGHT, 7'($urandom_range(127, 100)), 16'($urandom));
			default: send_word(OP_CONCEPT, 7'($urandom_range(127, 10)), 16'($urandom));
		endcase
	endtask

	task automatic random_phase(int count);
		int start;
		int r;
		start = items_sent;
		while (items_sent - start < count) begin
			if ($urandom_range(49) == 0) calm = ~calm;
			r = $urandom_range(99);
			if (r < 70) send_record($urandom_range(3) == 0);
			else if (r < 82) send_word(OP_WEIGHT, 7'($urandom_range(99)), pick_value());
			else if (r < 90) send_word(OP_FINISH, 7'($urandom), 16'($urandom));
			else send_noise();
		end
		calm = 1'b0;
	endtask

	// Receiver with random stalls and requested long hold-offs.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser[0]);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (calm) begin
				m_tready <= 1'b1;
			end else begin
				if ($urandom_range(199) == 0) stall_left = $urandom_range(150, 30);
				m_tready <= ($urandom_range(9) < 7);
			end
		end
	end

	initial begin
		#50ms;
		$display("cognitive_map_inference_error verification failed");
		$finish;
	end

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		hold_request = 0;
		items_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole weight store before any inference reads it.
		for (int i = 0; i < 100; i++)
			send_word(OP_WEIGHT, 7'(i), (i % 11 == 0) ? 16'h8000 : pick_value());

		// Directed part: extremes, ignored words, finish, target and divisor corners.
		send_word(OP_WEIGHT, 7'd100, 16'h7FFF);
		send_word(OP_WEIGHT, 7'd127, 16'h8000);
		send_word(OP_CONCEPT, 7'd10, 16'h1234);
		send_word(OP_CONCEPT, 7'd127, 16'hFFFF);
		send_word(OP_NONE, 7'd127, 16'hFFFF);
		for (int i = 0; i < 10; i++) send_word(OP_CONCEPT, 7'(i), 16'h7FFF);
		for (int i = 0; i < 10; i++)
			send_word(OP_CONCEPT, 7'(i), (i == 9) ? 16'h8000 : 16'h0000);
		send_word(OP_FINISH, 7'd0, 16'd0);
		wait_idle();
		write_reg(REG_TARGET, 16'hFFFF);
		write_reg(REG_DIVISOR, 16'd0);
		send_record(1'b0);
		send_word(OP_FINISH, 7'h7F, 16'hFFFF);
		send_word(OP_FINISH, 7'd0, 16'd0);
		wait_idle();

		// Random phases over several register settings.
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: begin
					write_reg(REG_DIVISOR, 16'd700);
					write_reg(REG_TARGET, 16'd9);
				end
				1: begin
					write_reg(REG_DIVISOR, 16'd1);
					write_reg(REG_TARGET, 16'd0);
				end
				2: begin
					write_reg(REG_DIVISOR, 16'hFFFF);
					write_reg(REG_TARGET, 16'd15);
				end
				3: begin
					write_reg(REG_DIVISOR, 16'd0);
					write_reg(REG_TARGET, 16'd5);
				end
				default: begin
					write_reg(REG_DIVISOR, 16'($urandom_range(65535, 1)));
					write_reg(REG_TARGET, 16'($urandom_range(15)));
				end
			endcase
			if (p == 1) begin
				// Long receiver hold-off while the sender keeps offering records.
				hold_request = 400;
				calm = 1'b1;
				for (int k = 0; k < 6; k++) send_record(1'b0);
				calm = 1'b0;
			end
			random_phase(PHASE_ITEMS);
			wait_idle();
		end

		if (sb.errors == 0) begin
			$display("cognitive_map_inference_error verification clean");
		end else begin
			$display("cognitive_map_inference_error verification failed");
		end
		$finish;
	end
endmodule

`default_nettype wire
